// File: rtl/audio_mix_adaptive_limiter_top_defines.svh
// Assertion macros used by the mixer limiter top module.
// Both macros sample on the rising edge of clock and are quiet while reset is high.
`ifndef AUDIO_MIX_ADAPTIVE_LIMITER_TOP_DEFINES_SVH
`define AUDIO_MIX_ADAPTIVE_LIMITER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that prop holds at every rising clock edge outside reset.
`define AMAL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("audio mixer limiter: invariant violated");
// Checks that nxt holds in the cycle after cond.
`define AMAL_ASSERT_NEXT(label, cond, nxt) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error("audio mixer limiter: sequence violated");
`else
`define AMAL_ASSERT(label, prop)
`define AMAL_ASSERT_NEXT(label, cond, nxt)
`endif
`endif

// File: rtl/amal_pkg.sv
`default_nettype none

package amal_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int POS_W       = $clog2(STORE_DEPTH);
   localparam int SIZE_W      = POS_W + 1;
   localparam int SAMPLE_W    = 16;
   localparam int ACC_W       = 32;
   localparam int GAIN_W      = 7;
   localparam int MAX_W       = 15;
   localparam int CH_CNT_W    = 4;
   localparam int CH_IDX_W    = 3;
   localparam int FS_W        = 11;
   localparam int FPROD_W     = FS_W + CH_CNT_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int Q_SHIFT     = 6;
   localparam int ATTEN_SHIFT = 5;
   localparam int PROD_W      = ACC_W + GAIN_W + 1;
   localparam int V_W         = PROD_W - Q_SHIFT;
   localparam int DIVIDEND_W  = MAX_W + Q_SHIFT;
   localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

   typedef logic [POS_W-1:0]           pos_type;
   typedef logic [SIZE_W-1:0]          size_type;
   typedef logic [FPROD_W-1:0]         fprod_type;
   typedef logic [CH_CNT_W-1:0]        ch_cnt_type;
   typedef logic [CH_IDX_W-1:0]        ch_idx_type;
   typedef logic [FS_W-1:0]            fs_type;
   typedef logic [GAIN_W-1:0]          gain_type;
   typedef logic [MAX_W-1:0]           max_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [ACC_W-1:0]           acc_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [V_W-1:0]      v_type;
   typedef logic [DIVIDEND_W-1:0]      dividend_type;
   typedef logic [DIV_CNT_W-1:0]       div_cnt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_RANGE     = 2'd0,
      CSR_CHANNELS      = 2'd1,
      CSR_FRAME_SAMPLES = 2'd2,
      CSR_PRE_ATTENUATE = 2'd3
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_MUL,
      ST_CHK,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   localparam gain_type   GAIN_INIT           = gain_type'(32);
   localparam gain_type   GAIN_MAX            = gain_type'(64);
   localparam max_type    MAX_RANGE_RESET     = max_type'(32767);
   localparam ch_cnt_type CHANNELS_RESET      = ch_cnt_type'(1);
   localparam fs_type     FRAME_SAMPLES_RESET = fs_type'(160);
   localparam ch_cnt_type MAX_CH              = ch_cnt_type'(8);
   localparam fprod_type  FPROD_DEPTH         = fprod_type'(STORE_DEPTH);
   localparam size_type   SIZE_DEPTH          = size_type'(STORE_DEPTH);
   localparam v_type      SAT_POS             = v_type'(32767);
   localparam v_type      SAT_NEG             = -SAT_POS;
   localparam sample_type ATTEN_BIAS          = sample_type'((1 << ATTEN_SHIFT) - 1);

endpackage

`default_nettype wire

// File: rtl/audio_mix_adaptive_limiter_top.sv
`default_nettype none

// Audio mixer with automatic gain limiter. Sources present one frame each of
// interleaved 16-bit samples, one request per sample, source after source; the
// first source of a frame overwrites the 32-bit running sums held in a 1024-entry
// block RAM, later sources add to them, and each request of the last source returns
// one response carrying the sum scaled by a Q6 gain (saturated to +/-32767), or
// +/-max_range when the first channel of its group overflowed, in which case the
// gain is recomputed as (max_range*64)/|sum| by a bit-serial divider. The gain
// steps up by one per frame until it reaches 64. One request is worked on at a
// time, because every request reads, updates and writes back one RAM entry: a
// request of a source that is not the last goes through a RAM read, then add and
// write back; a request of the last source goes through read, add, multiply,
// limit check and hand-off to the output register, and a request that triggers a
// gain recompute also waits on the 21-bit bit-serial divider. The response sits in
// an output register, so the next request is taken while a response still waits on
// rsp_stall. Configuration registers (max_range, channels, frame_samples,
// pre_attenuate at indexes 0 to 3) are written through the csr port and may only
// change while the block is idle. A frame holds frame_samples*channels positions,
// clipped to the RAM depth. The RAM has no reset: the first source after reset must
// be flagged first_source so that every position is written before it is read.
`include "audio_mix_adaptive_limiter_top_defines.svh"

module audio_mix_adaptive_limiter_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Configuration write port.
   input  wire logic                                csr_write_en,
   input  wire logic [amal_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [amal_pkg::CSR_DATA_W-1:0]     csr_write_data,
   // Request channel.
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [amal_pkg::SAMPLE_W-1:0] req_sample_in,
   input  wire logic                                req_first_source,
   input  wire logic                                req_last_source,
   // Response channel.
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [amal_pkg::SAMPLE_W-1:0]     rsp_mixed_sample,
   output logic                                     rsp_clamped,
   output logic                                     rsp_frame_end
);

   // Configuration registers.
   amal_pkg::max_type    max_range_ff;
   amal_pkg::ch_cnt_type channels_ff;
   amal_pkg::fs_type     frame_samples_ff;
   logic                 pre_attenuate_ff;

   // Frame tracking and limiter state.
   amal_pkg::pos_type    position_ff, position_in;
   amal_pkg::ch_idx_type channel_ff, channel_in;
   amal_pkg::gain_type   gain_ff, gain_in;
   logic                 group_clamp_ff, group_clamp_in;
   amal_pkg::state_type  state_ff, state_in;

   // The request being worked on.
   amal_pkg::sample_type item_sample_ff;
   logic                 item_first_ff;
   logic                 item_last_ff;
   amal_pkg::pos_type    item_pos_ff;
   logic                 item_ch_zero_ff;
   logic                 item_frame_end_ff;
   amal_pkg::acc_type    acc_ff, acc_in;
   amal_pkg::prod_type   prod_ff;

   // Result waiting for the output register.
   amal_pkg::sample_type res_sample_ff, res_sample_in;
   logic                 res_clamped_ff, res_clamped_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   amal_pkg::sample_type rsp_sample_ff;
   logic                 rsp_clamped_ff;
   logic                 rsp_frame_end_ff;

   // Frame geometry.
   amal_pkg::ch_cnt_type nch;
   amal_pkg::fs_type     fs_eff;
   amal_pkg::fprod_type  fprod;
   amal_pkg::size_type   frame_size;

   // Request-side position resolution.
   logic                 req_accept;
   logic                 pos_wrap;
   amal_pkg::pos_type    pos_eff;
   amal_pkg::ch_idx_type ch_eff;
   amal_pkg::size_type   pos_inc;
   amal_pkg::ch_cnt_type ch_inc;
   amal_pkg::sample_type sample_att;

   // Limiter datapath.
   amal_pkg::acc_type    ram_rd_data;
   amal_pkg::v_type      scaled;
   amal_pkg::v_type      scaled_mag;
   logic                 over_limit;
   logic                 clamp_now;
   amal_pkg::sample_type clamp_pos;
   amal_pkg::sample_type clamp_neg;
   amal_pkg::sample_type sat_sample;
   amal_pkg::acc_type    abs_sum;

   // Control between the sequencer and the divider and output register.
   logic                   div_start;
   amal_pkg::dividend_type div_quotient;
   amal_pkg::div_stat_type div_stat;
   logic                   out_load;
   logic                   out_free;

   // ------------------------------------------------------------------------
   // Configuration port. The user must write only while the block is idle; the block does not enforce it.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff     <= amal_pkg::MAX_RANGE_RESET;
         channels_ff      <= amal_pkg::CHANNELS_RESET;
         frame_samples_ff <= amal_pkg::FRAME_SAMPLES_RESET;
         pre_attenuate_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (amal_pkg::csr_reg_type'(csr_index))
            amal_pkg::CSR_MAX_RANGE: begin
               max_range_ff <= amal_pkg::max_type'(csr_write_data);
            end
            amal_pkg::CSR_CHANNELS: begin
               channels_ff <= amal_pkg::ch_cnt_type'(csr_write_data);
            end
            amal_pkg::CSR_FRAME_SAMPLES: begin
               frame_samples_ff <= amal_pkg::fs_type'(csr_write_data);
            end
            amal_pkg::CSR_PRE_ATTENUATE: begin
               pre_attenuate_ff <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Frame geometry: a channel count of zero acts as one and counts above
   // eight act as eight; zero frame samples act as one; the frame is clipped
   // to the RAM depth.
   // ------------------------------------------------------------------------
   always_comb begin
      if (channels_ff == '0) begin
         nch = amal_pkg::ch_cnt_type'(1);
      end else if (channels_ff > amal_pkg::MAX_CH) begin
         nch = amal_pkg::MAX_CH;
      end else begin
         nch = channels_ff;
      end
      fs_eff = (frame_samples_ff == '0) ? amal_pkg::fs_type'(1) : frame_samples_ff;
      fprod  = amal_pkg::fprod_type'(fs_eff) * amal_pkg::fprod_type'(nch);
      if (fprod > amal_pkg::FPROD_DEPTH) begin
         frame_size = amal_pkg::SIZE_DEPTH;
      end else begin
         frame_size = amal_pkg::size_type'(fprod);
      end
   end

   // ------------------------------------------------------------------------
   // Position of the incoming request. A configuration change that leaves the
   // position beyond the frame restarts the frame, and the channel counter
   // restarts at every frame start. The counters advance as the request is
   // taken, since nothing later in the request depends on them.
   // ------------------------------------------------------------------------
   assign req_stall  = (state_ff != amal_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      pos_wrap = ({1'b0, position_ff} >= frame_size);
      pos_eff  = pos_wrap ? '0 : position_ff;
      ch_eff   = (pos_eff == '0) ? '0 : channel_ff;
      pos_inc  = {1'b0, pos_eff} + 1'b1;
      ch_inc   = {1'b0, ch_eff} + 1'b1;

      position_in = position_ff;
      channel_in  = channel_ff;
      if (req_accept) begin
         if (pos_inc >= frame_size) begin
            position_in = '0;
            channel_in  = '0;
         end else begin
            position_in = pos_inc[amal_pkg::POS_W-1:0];
            channel_in  = (ch_inc >= nch) ? '0 : ch_inc[amal_pkg::CH_IDX_W-1:0];
         end
      end

      // Divide by 32 truncating toward zero: bias negative samples first.
      if (pre_attenuate_ff) begin
         sample_att = (req_sample_in + (req_sample_in[amal_pkg::SAMPLE_W-1] ?
                       amal_pkg::ATTEN_BIAS : amal_pkg::sample_type'(0))) >>>
                      amal_pkg::ATTEN_SHIFT;
      end else begin
         sample_att = req_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_sample_ff    <= sample_att;
         item_first_ff     <= req_first_source;
         item_last_ff      <= req_last_source;
         item_pos_ff       <= pos_eff;
         item_ch_zero_ff   <= (ch_eff == '0);
         item_frame_end_ff <= (pos_inc == frame_size);
      end
   end

   // ------------------------------------------------------------------------
   // Running sums. The entry is read as the request is taken and written back
   // in the following cycle; the next request is only taken after the write, so no
   // forwarding is needed.
   // ------------------------------------------------------------------------
   amal_ram #(
      .WIDTH (amal_pkg::ACC_W),
      .DEPTH (amal_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (state_ff == amal_pkg::ST_ACC),
      .wr_addr (item_pos_ff),
      .wr_data (acc_in),
      .rd_en   (req_accept),
      .rd_addr (pos_eff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (item_first_ff) begin
         acc_in = amal_pkg::acc_type'(item_sample_ff);
      end else begin
         acc_in = ram_rd_data + amal_pkg::acc_type'(item_sample_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Limiter datapath. The product is registered in ST_MUL and the limit is
   // checked in ST_CHK. An arithmetic shift of the Q6 product rounds toward
   // minus infinity.
   // ------------------------------------------------------------------------
   always_comb begin
      scaled     = amal_pkg::v_type'(prod_ff >>> amal_pkg::Q_SHIFT);
      scaled_mag = scaled[amal_pkg::V_W-1] ? -scaled : scaled;
      over_limit = (scaled_mag > amal_pkg::v_type'(max_range_ff));
      clamp_now  = item_ch_zero_ff ? over_limit : group_clamp_ff;
      clamp_pos  = amal_pkg::sample_type'(max_range_ff);
      clamp_neg  = -clamp_pos;
      abs_sum    = acc_ff[amal_pkg::ACC_W-1] ? -acc_ff : acc_ff;

      if (scaled > amal_pkg::SAT_POS) begin
         sat_sample = amal_pkg::sample_type'(amal_pkg::SAT_POS);
      end else if (scaled < amal_pkg::SAT_NEG) begin
         sat_sample = amal_pkg::sample_type'(amal_pkg::SAT_NEG);
      end else begin
         sat_sample = amal_pkg::sample_type'(scaled);
      end

      // A zero sum clamps to the positive limit.
      if (clamp_now) begin
         res_sample_in = acc_ff[amal_pkg::ACC_W-1] ? clamp_neg : clamp_pos;
      end else begin
         res_sample_in = sat_sample;
      end
      res_clamped_in = clamp_now;
   end

   amal_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({max_range_ff, {amal_pkg::Q_SHIFT{1'b0}}}),
      .divisor  (abs_sum),
      .quotient (div_quotient),
      .status   (div_stat)
   );

   // ------------------------------------------------------------------------
   // Sequencer: next state, gain and group clamp updates.
   // ------------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      gain_in        = gain_ff;
      group_clamp_in = group_clamp_ff;
      div_start      = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         amal_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = amal_pkg::ST_ACC;
            end
         end
         amal_pkg::ST_ACC: begin
            if (item_last_ff) begin
               // The gain creeps up once per frame, before the first sample is scaled.
               if ((item_pos_ff == '0) && (gain_ff < amal_pkg::GAIN_MAX)) begin
                  gain_in = gain_ff + 1'b1;
               end
               state_in = amal_pkg::ST_MUL;
            end else begin
               state_in = amal_pkg::ST_IDLE;
            end
         end
         amal_pkg::ST_MUL: begin
            state_in = amal_pkg::ST_CHK;
         end
         amal_pkg::ST_CHK: begin
            if (item_ch_zero_ff) begin
               group_clamp_in = over_limit;
            end
            if (item_ch_zero_ff && over_limit && (acc_ff != '0)) begin
               div_start = 1'b1;
               state_in  = amal_pkg::ST_DIV;
            end else begin
               state_in = amal_pkg::ST_OUT;
            end
         end
         amal_pkg::ST_DIV: begin
            if (div_stat.done) begin
               gain_in  = div_quotient[amal_pkg::GAIN_W-1:0];
               state_in = amal_pkg::ST_OUT;
            end
         end
         amal_pkg::ST_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = amal_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = amal_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= amal_pkg::ST_IDLE;
         position_ff    <= '0;
         channel_ff     <= '0;
         gain_ff        <= amal_pkg::GAIN_INIT;
         group_clamp_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         position_ff    <= position_in;
         channel_ff     <= channel_in;
         gain_ff        <= gain_in;
         group_clamp_ff <= group_clamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == amal_pkg::ST_ACC) begin
         acc_ff <= acc_in;
      end
      if (state_ff == amal_pkg::ST_MUL) begin
         prod_ff <= amal_pkg::prod_type'($signed(acc_ff)) *
                    amal_pkg::prod_type'($signed({1'b0, gain_ff}));
      end
      if (state_ff == amal_pkg::ST_CHK) begin
         res_sample_ff  <= res_sample_in;
         res_clamped_ff <= res_clamped_in;
      end
   end

   // ------------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------------
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_sample_ff    <= res_sample_ff;
         rsp_clamped_ff   <= res_clamped_ff;
         rsp_frame_end_ff <= item_frame_end_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sample_ff;
   assign rsp_clamped      = rsp_clamped_ff;
   assign rsp_frame_end    = rsp_frame_end_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // A recomputed gain is always below the gain that overflowed, so the gain
   // never leaves its range.
   `AMAL_ASSERT(a_gain_range, gain_ff <= amal_pkg::GAIN_MAX)
   // A request of a source that is not the last finishes right after its write-back.
   `AMAL_ASSERT_NEXT(a_plain_done, (state_ff == amal_pkg::ST_ACC) && !item_last_ff, state_ff == amal_pkg::ST_IDLE)
   // The divider is only started while free and the sequencer then waits on it.
   `AMAL_ASSERT_NEXT(a_div_start, div_start, (state_ff == amal_pkg::ST_DIV) && div_stat.busy)
   // A clamped response carries exactly the configured limit.
   `AMAL_ASSERT(a_clamp_value, (rsp_valid_ff && rsp_clamped_ff) |-> ((rsp_sample_ff == clamp_pos) || (rsp_sample_ff == clamp_neg)))

endmodule

`default_nettype wire

// File: rtl/amal_ram.sv
`default_nettype none

module amal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/amal_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, for the gain recompute.
module amal_div (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire amal_pkg::dividend_type dividend,
   input  wire amal_pkg::acc_type      divisor,
   output amal_pkg::dividend_type      quotient,
   output amal_pkg::div_stat_type      status
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   amal_pkg::div_cnt_type          cnt_ff, cnt_in;
   amal_pkg::acc_type              rem_ff, rem_in;
   amal_pkg::acc_type              dvs_ff, dvs_in;
   amal_pkg::dividend_type         quo_ff, quo_in;
   logic [amal_pkg::ACC_W:0]       trial;
   logic [amal_pkg::ACC_W:0]       diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      // Shift the next dividend bit into the partial remainder.
      trial   = {rem_ff, quo_ff[amal_pkg::DIVIDEND_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = amal_pkg::div_cnt_type'(amal_pkg::DIVIDEND_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!diff[amal_pkg::ACC_W]) begin
            rem_in = diff[amal_pkg::ACC_W-1:0];
            quo_in = {quo_ff[amal_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[amal_pkg::ACC_W-1:0];
            quo_in = {quo_ff[amal_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == amal_pkg::div_cnt_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // The run is judged on checks and on the watchdog only. These constants set how much
   // stimulus goes in and how long a quiet stretch may last before the run is declared hung.
   localparam int RANDOM_ITEMS    = 350;
   localparam int PHASE_ITEMS     = 60;
   localparam int SETTLE_CYCLES   = 40;
   localparam int PRESSURE_HOLD   = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_REPORTS     = 50;
   localparam int PARTIAL_ITEMS   = 30;
   localparam int SHORT_ADDS      = 8;

   typedef logic [amal_pkg::CSR_DATA_W-1:0] csr_data_type;

   typedef struct packed {
      amal_pkg::sample_type value;
      logic                 first;
      logic                 last;
   } mix_request_type;

   typedef struct packed {
      amal_pkg::sample_type mixed;
      logic                 clamped;
      logic                 frame_end;
   } mix_result_type;

   // Clock, reset and every input of the block start at known values.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   amal_pkg::csr_reg_type csr_index = amal_pkg::CSR_MAX_RANGE;
   csr_data_type          csr_write_data = '0;
   logic                  req_valid = 1'b0;
   amal_pkg::sample_type  req_sample_in = '0;
   logic                  req_first_source = 1'b0;
   logic                  req_last_source = 1'b0;
   logic                  rsp_stall = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   amal_pkg::sample_type  rsp_mixed_sample;
   logic                  rsp_clamped;
   logic                  rsp_frame_end;

   always #2 clock = ~clock;

   audio_mix_adaptive_limiter_top DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .req_first_source (req_first_source),
      .req_last_source  (req_last_source),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mixed_sample (rsp_mixed_sample),
      .rsp_clamped      (rsp_clamped),
      .rsp_frame_end    (rsp_frame_end)
   );

   // Requests waiting to be offered, and the mixed samples the limiter owes us.
   mix_request_type sample_queue[$];
   mix_result_type  pending_mixes[$];

   // Our own copy of the register file, updated whenever the csr port writes.
   amal_pkg::max_type    cfg_max      = amal_pkg::MAX_RANGE_RESET;
   amal_pkg::ch_cnt_type cfg_channels = amal_pkg::CHANNELS_RESET;
   amal_pkg::fs_type     cfg_frame    = amal_pkg::FRAME_SAMPLES_RESET;
   logic                 cfg_atten    = 1'b0;

   // Mirror of the limiter state, advanced once per accepted request.
   amal_pkg::acc_type  mix_sums [amal_pkg::STORE_DEPTH];
   int                 mix_pos   = 0;
   int                 chan_idx  = 0;
   amal_pkg::gain_type cur_gain  = amal_pkg::GAIN_INIT;
   logic               grp_clamp = 1'b0;

   // Position tracker of the stimulus generator. It runs ahead of the mirror above and
   // only exists to make sure a running sum is never read before some source wrote it.
   int gen_pos = 0;
   bit gen_written [amal_pkg::STORE_DEPTH];

   // Bookkeeping shared between the processes.
   int  requests_queued = 0;
   int  requests_taken = 0;
   int  responses_seen = 0;
   int  clamp_seen = 0;
   int  mismatch_count = 0;
   int  settings_written = 0;
   int  hold_asked = 0;
   int  hold_done = 0;
   bit  send_idle_on = 1'b1;
   bit  recv_idle_on = 1'b1;
   int  gap_left = 0;
   int  hold_left = 0;
   mix_request_type cur_request;
   mix_result_type  want;

   // Channel count as the block uses it: zero acts as one, anything above eight as eight.
   function automatic int group_width();
      if (cfg_channels == 0) return 1;
      if (cfg_channels > amal_pkg::MAX_CH) return int'(amal_pkg::MAX_CH);
      return int'(cfg_channels);
   endfunction

   // Positions per frame, with a zero frame size acting as one and the product clipped
   // to the depth of the sum store.
   function automatic int frame_len();
      int fs;
      int n;
      fs = (cfg_frame == 0) ? 1 : int'(cfg_frame);
      n = fs * group_width();
      return (n > amal_pkg::STORE_DEPTH) ? amal_pkg::STORE_DEPTH : n;
   endfunction

   // Most draws give no gap or a short one; once in a while a long one shows up.
   function automatic int idle_length(input bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Sample mix: full-range noise, the corner values, quiet signal and loud signal that
   // pushes the sums past the limit when several sources stack up.
   function automatic amal_pkg::sample_type pick_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return amal_pkg::sample_type'($urandom);
      if (r < 5) begin
         case ($urandom_range(0, 4))
            0: return amal_pkg::sample_type'(-32768);
            1: return amal_pkg::sample_type'(32767);
            2: return amal_pkg::sample_type'(-1);
            3: return amal_pkg::sample_type'(0);
            default: return amal_pkg::sample_type'(1);
         endcase
      end
      if (r < 8) return amal_pkg::sample_type'(int'($urandom_range(0, 400)) - 200);
      r = $urandom_range(20000, 32767);
      return amal_pkg::sample_type'(($urandom_range(0, 1) != 0) ? -r : r);
   endfunction

   // Appends one request. A request that would add to a sum nobody has written yet is
   // turned into a first-source request, so the store is never read uninitialized.
   function automatic void queue_request(input amal_pkg::sample_type value, input bit first,
                                         input bit last);
      mix_request_type item;
      if (gen_pos >= frame_len()) gen_pos = 0;
      if (!first && !gen_written[gen_pos]) first = 1'b1;
      gen_written[gen_pos] = 1'b1;
      item.value = value;
      item.first = first;
      item.last  = last;
      sample_queue.push_back(item);
      requests_queued++;
      gen_pos++;
      if (gen_pos >= frame_len()) gen_pos = 0;
   endfunction

   // A well-formed frame: every source streams a whole frame, the first one overwrites
   // the sums and the last one gets the mixed output back.
   function automatic int queue_frame(input int sources);
      for (int src = 0; src < sources; src++)
         for (int p = 0; p < frame_len(); p++)
            queue_request(pick_sample(), src == 0, src == sources - 1);
      return sources * frame_len();
   endfunction

   // Q6 scaling of a sum: the product is exact and the shift floors toward minus infinity.
   function automatic longint scale_by_gain(input int sum);
      return (longint'(sum) * longint'(cur_gain)) >>> amal_pkg::Q_SHIFT;
   endfunction

   // Accumulates one accepted request into the mirrored store and, when it belongs to
   // the last source, works out the mixed sample the limiter has to return.
   function automatic void predict_mix(input amal_pkg::sample_type value, input logic first,
                                       input logic last);
      int                s;
      int                sum;
      amal_pkg::acc_type acc;
      longint            v;
      longint            q;
      mix_result_type    r;
      if (mix_pos >= frame_len()) begin
         mix_pos  = 0;
         chan_idx = 0;
      end
      if (mix_pos == 0) chan_idx = 0;
      s = value;
      if (cfg_atten) s = s / 32;
      acc = first ? amal_pkg::acc_type'(s) : mix_sums[mix_pos] + amal_pkg::acc_type'(s);
      mix_sums[mix_pos] = acc;
      if (last) begin
         sum = acc;
         // The gain creeps up by one at the start of every emitted frame.
         if (mix_pos == 0 && cur_gain < amal_pkg::GAIN_MAX) cur_gain++;
         // Only the first channel of a group decides whether the group clamps.
         if (chan_idx == 0) begin
            v = scale_by_gain(sum);
            grp_clamp = ((v < 0) ? -v : v) > longint'(cfg_max);
            if (grp_clamp && sum != 0) begin
               q = (longint'(cfg_max) * 64) / longint'(sum);
               cur_gain = amal_pkg::gain_type'((q < 0) ? -q : q);
            end
         end
         if (grp_clamp) begin
            // A zero sum counts as positive here.
            v = (sum < 0) ? -longint'(cfg_max) : longint'(cfg_max);
         end else begin
            v = scale_by_gain(sum);
            if (v > 32767) v = 32767;
            if (v < -32767) v = -32767;
         end
         r.mixed     = v[amal_pkg::SAMPLE_W-1:0];
         r.clamped   = grp_clamp;
         r.frame_end = (mix_pos + 1 == frame_len());
         pending_mixes.push_back(r);
      end
      chan_idx++;
      if (chan_idx >= group_width()) chan_idx = 0;
      mix_pos++;
      if (mix_pos >= frame_len()) begin
         mix_pos  = 0;
         chan_idx = 0;
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint exp_val);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH %s on response %0d: got %0d, expected %0d",
                  what, responses_seen, got, exp_val);
   endtask

   // Waits until every queued request went in and every owed response came out, then
   // gives the block time to finish requests that return nothing.
   task automatic drain();
      while (requests_taken != requests_queued || pending_mixes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers on consecutive cycles once the block has gone idle.
   task automatic reprogram(input int max_val, input int ch_val, input int fs_val,
                            input int atten_val);
      drain();
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= amal_pkg::CSR_MAX_RANGE;
      csr_write_data <= csr_data_type'(max_val);
      @(posedge clock);
      csr_index      <= amal_pkg::CSR_CHANNELS;
      csr_write_data <= csr_data_type'(ch_val);
      @(posedge clock);
      csr_index      <= amal_pkg::CSR_FRAME_SAMPLES;
      csr_write_data <= csr_data_type'(fs_val);
      @(posedge clock);
      csr_index      <= amal_pkg::CSR_PRE_ATTENUATE;
      csr_write_data <= csr_data_type'(atten_val);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cfg_max      = amal_pkg::max_type'(max_val);
      cfg_channels = amal_pkg::ch_cnt_type'(ch_val);
      cfg_frame    = amal_pkg::fs_type'(fs_val);
      cfg_atten    = atten_val[0];
      settings_written++;
   endtask

   // Request driver. A request is taken at an edge where valid is high and stall is low;
   // the mirror is advanced right there. A new request is offered only once the current
   // one is gone, so a stalled request never changes.
   always @(posedge clock) begin
      if (reset) begin
         req_valid        <= 1'b0;
         req_sample_in    <= '0;
         req_first_source <= 1'b0;
         req_last_source  <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_mix(req_sample_in, req_first_source, req_last_source);
            requests_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               cur_request = sample_queue.pop_front();
               req_valid        <= 1'b1;
               req_sample_in    <= cur_request.value;
               req_first_source <= cur_request.first;
               req_last_source  <= cur_request.last;
               gap_left = idle_length(send_idle_on);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and stall generator. Each response taken is checked against the
   // oldest owed result. The stall is computed once per cycle and driven once; a requested
   // hold-off keeps it high for a long, counted stretch so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (rsp_clamped === 1'b1) clamp_seen++;
            if (pending_mixes.size() == 0) begin
               report_mismatch("response with nothing owed", rsp_mixed_sample, 0);
            end else begin
               want = pending_mixes.pop_front();
               if (rsp_mixed_sample !== want.mixed)
                  report_mismatch("mixed_sample", rsp_mixed_sample, want.mixed);
               if (rsp_clamped !== want.clamped)
                  report_mismatch("clamped", rsp_clamped, want.clamped);
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch("frame_end", rsp_frame_end, want.frame_end);
            end
         end
         if (hold_done != hold_asked) begin
            hold_done++;
            hold_left = PRESSURE_HOLD;
         end else if (hold_left == 0) begin
            hold_left = idle_length(recv_idle_on);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: any handshake or register write counts as progress. A long run of cycles
   // without any means the block has hung.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Stimulus sequence: directed corners first, then a full clipped frame, then frames of
   // a single position, then random phases under changing settings.
   initial begin : stimulus
      int random_items;
      int phase_items;
      int phase_count;
      int max_val;
      int ch_val;
      int fs_val;
      int r;
      int n;
      random_items = 0;
      phase_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Stereo, two groups per frame. A single-source frame with the sample extremes, a
      // two-source frame that overflows and clamps both groups, and a frame whose second
      // channel sums to zero while the first channel clamps.
      reprogram(32767, 2, 2, 0);
      queue_request(amal_pkg::sample_type'(32767), 1, 1);
      queue_request(amal_pkg::sample_type'(-32768), 1, 1);
      queue_request(amal_pkg::sample_type'(0), 1, 1);
      queue_request(amal_pkg::sample_type'(-1), 1, 1);
      for (int src = 0; src < 2; src++) begin
         queue_request(amal_pkg::sample_type'(32767), src == 0, src == 1);
         queue_request(amal_pkg::sample_type'(32767), src == 0, src == 1);
         queue_request(amal_pkg::sample_type'(-32768), src == 0, src == 1);
         queue_request(amal_pkg::sample_type'(-32768), src == 0, src == 1);
      end
      queue_request(amal_pkg::sample_type'(32767), 1, 0);
      queue_request(amal_pkg::sample_type'(5), 1, 0);
      queue_request(amal_pkg::sample_type'(-32768), 1, 0);
      queue_request(amal_pkg::sample_type'(7), 1, 0);
      queue_request(amal_pkg::sample_type'(32767), 0, 1);
      queue_request(amal_pkg::sample_type'(-5), 0, 1);
      queue_request(amal_pkg::sample_type'(-32768), 0, 1);
      queue_request(amal_pkg::sample_type'(-7), 0, 1);

      // Pre-attenuation truncates toward zero, so small negative samples vanish. A tight
      // limit makes the loud frame clamp.
      reprogram(100, 1, 3, 1);
      queue_request(amal_pkg::sample_type'(-33), 1, 1);
      queue_request(amal_pkg::sample_type'(-31), 1, 1);
      queue_request(amal_pkg::sample_type'(31), 1, 1);
      queue_request(amal_pkg::sample_type'(-32768), 1, 0);
      queue_request(amal_pkg::sample_type'(32767), 1, 0);
      queue_request(amal_pkg::sample_type'(-1), 1, 0);
      queue_request(amal_pkg::sample_type'(63), 0, 1);
      queue_request(amal_pkg::sample_type'(-64), 0, 1);
      queue_request(amal_pkg::sample_type'(-1), 0, 1);

      // A zero limit clamps everything to zero and drives the gain to zero, after which
      // it has to climb back one step per frame.
      reprogram(0, 1, 2, 0);
      queue_request(amal_pkg::sample_type'(1000), 1, 1);
      queue_request(amal_pkg::sample_type'(-1000), 1, 1);
      queue_request(amal_pkg::sample_type'(500), 1, 1);
      queue_request(amal_pkg::sample_type'(-500), 1, 1);

      // Out-of-range channel and frame settings: the product is clipped to the full store.
      // One whole frame goes through, then the next frame stops partway so that the
      // following, much shorter setting finds the position past its end.
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      reprogram(32767, 15, 2047, 0);
      void'(queue_frame(1));
      for (int p = 0; p < PARTIAL_ITEMS; p++) queue_request(pick_sample(), 1, 0);

      // One position per frame with zero channels and zero frame size. Loud samples pile
      // up on that single position; the last two requests emit.
      reprogram(32767, 0, 0, 0);
      for (int k = 1; k <= SHORT_ADDS; k++)
         queue_request(amal_pkg::sample_type'(-32768), k == 1, k >= SHORT_ADDS - 1);

      // Random phases. Most traffic is whole frames from one to four sources with random
      // content; the rest is loose requests with random source flags.
      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 9);
         if (r < 4) max_val = 32767;
         else if (r < 6) max_val = $urandom_range(1, 32767);
         else if (r < 9) max_val = $urandom_range(1, 3000);
         else max_val = 1;
         ch_val = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
         fs_val = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
         if ($urandom_range(0, 19) == 0) fs_val = 0;
         reprogram(max_val, ch_val, fs_val, $urandom_range(0, 1));
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         if (phase_count == 1 || phase_count == 4) hold_asked++;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
               n = (frame_len() > 48) ? $urandom_range(1, 2) : $urandom_range(1, 4);
               phase_items += queue_frame(n);
            end else begin
               n = $urandom_range(1, 12);
               for (int k = 0; k < n; k++)
                  queue_request(pick_sample(), $urandom_range(0, 3) == 0,
                                $urandom_range(0, 1) != 0);
               phase_items += n;
            end
         end
         random_items += phase_items;
         phase_count++;
      end

      drain();
      $display("Mixed %0d requests into %0d responses (%0d clamped) under %0d register settings.",
               requests_taken, responses_seen, clamp_seen, settings_written);
      $display("Included a clipped full-depth frame, single-position frames and receiver hold-offs.");
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
